@@ hdl/cbm_pkg.sv @@
// shared types and constants for the cartridge bank mapper
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

	localparam int ROM_BANK_BYTES = 16384;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int ROM_OFS_BITS   = 14;
	localparam int RAM_OFS_BITS   = 13;
	localparam int CFG_IDX_BITS   = 1;

	localparam logic [7:0] BYTE_FF      = 8'hFF;
	localparam logic [7:0] ROM_USED_RST = 8'd8;
	localparam logic [2:0] RAM_USED_RST = 3'd1;
	localparam logic [3:0] RAM_EN_KEY   = 4'hA;

	// bus address regions, by address bits 15:13
	localparam logic [2:0] RGN_ENABLE  = 3'd0;
	localparam logic [2:0] RGN_LOWBANK = 3'd1;
	localparam logic [2:0] RGN_UPPER   = 3'd2;
	localparam logic [2:0] RGN_MODE    = 3'd3;
	localparam logic [2:0] RGN_RAM     = 3'd5;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ROM_USED = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RAM_USED = 1'd1;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LOAD  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SRC_FF  = 2'd0,
		SRC_ROM = 2'd1,
		SRC_RAM = 2'd2
	} src_t;

	typedef struct packed {
		logic rom_re;
		logic rom_we;
		logic ram_re;
		logic ram_we;
		logic err;
		src_t src;
	} cbm_req_t;

endpackage
`default_nettype wire

@@ hdl/cbm_bytemem.sv @@
// single-port byte memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module cbm_bytemem #(
	parameter int DEPTH = 131072
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [7:0]               wdata,
	output logic      [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/cbm_ctrl.sv @@
// bank registers, config registers and bus access decode
`timescale 1ns / 1ps
`default_nettype none
module cbm_ctrl #(
	parameter int ROM_BANKS = 8,
	parameter int RAM_BANKS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              fire,
	input  wire logic [1:0]                        op,
	input  wire logic [15:0]                       bus_address,
	input  wire logic [16:0]                       load_offset,
	input  wire logic [7:0]                        data,
	input  wire logic                              cfg_fire,
	input  wire logic [cbm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [7:0]                        cfg_data,
	output logic [$clog2(ROM_BANKS*cbm_pkg::ROM_BANK_BYTES)-1:0] rom_addr,
	output logic [$clog2(RAM_BANKS*cbm_pkg::RAM_BANK_BYTES)-1:0] ram_addr,
	output cbm_pkg::cbm_req_t                      req
);
	import cbm_pkg::*;

	localparam int ROM_AW = $clog2(ROM_BANKS*ROM_BANK_BYTES);
	localparam int RAM_AW = $clog2(RAM_BANKS*RAM_BANK_BYTES);
	localparam logic [21:0] ROM_TOTAL_W = 22'(ROM_BANKS*ROM_BANK_BYTES);
	localparam logic [7:0]  ROM_BANKS_B = 8'(ROM_BANKS);
	localparam logic [2:0]  RAM_BANKS_B = 3'(RAM_BANKS);

	logic [4:0] low_bank_q;
	logic [1:0] upper_bits_q;
	logic       ram_enable_q;
	logic       ram_mode_q;
	logic [7:0] rom_used_q;
	logic [2:0] ram_used_q;

	logic [2:0]  rgn;
	logic [7:0]  rom_mask;
	logic [7:0]  rom_sel;
	logic        rom_bad;
	logic [1:0]  ram_sel;
	logic        ram_bad;
	logic [21:0] rom_full;
	logic [21:0] load_full;
	logic [14:0] ram_full;
	logic        wr_regs;

	assign rgn      = bus_address[15:13];
	assign rom_mask = rom_used_q - 8'd1;
	assign rom_sel  = (ram_mode_q ? {3'd0, low_bank_q} : {1'b0, upper_bits_q, low_bank_q})
		& rom_mask;
	assign rom_bad  = rom_sel >= ROM_BANKS_B;
	assign ram_sel  = ram_mode_q ? upper_bits_q : 2'd0;
	assign ram_bad  = (ram_used_q == 3'd0) || ({1'b0, ram_sel} >= ram_used_q)
		|| ({1'b0, ram_sel} >= RAM_BANKS_B);
	assign load_full = {5'd0, load_offset};
	assign ram_full  = {ram_sel, bus_address[RAM_OFS_BITS-1:0]};
	assign ram_addr  = ram_full[RAM_AW-1:0];

	always_comb begin
		req      = '{rom_re: 1'b0, rom_we: 1'b0, ram_re: 1'b0, ram_we: 1'b0,
			err: 1'b0, src: SRC_FF};
		rom_full = {8'd0, bus_address[ROM_OFS_BITS-1:0]};
		wr_regs  = 1'b0;
		case (op)
			OP_READ: begin
				case (rgn) inside
					RGN_ENABLE, RGN_LOWBANK: begin
						req.rom_re = fire;
						req.src    = SRC_ROM;
					end
					RGN_UPPER, RGN_MODE: begin
						rom_full = {rom_sel, bus_address[ROM_OFS_BITS-1:0]};
						if (rom_bad) begin
							req.err = 1'b1;
						end else begin
							req.rom_re = fire;
							req.src    = SRC_ROM;
						end
					end
					RGN_RAM: begin
						if (ram_bad) begin
							req.err = 1'b1;
						end else if (ram_enable_q) begin
							req.ram_re = fire;
							req.src    = SRC_RAM;
						end
					end
					default: req.err = 1'b1;
				endcase
			end
			OP_WRITE: begin
				case (rgn) inside
					RGN_ENABLE, RGN_LOWBANK, RGN_UPPER, RGN_MODE: wr_regs = fire;
					RGN_RAM: begin
						if (ram_bad) begin
							req.err = 1'b1;
						end else begin
							req.ram_we = fire && ram_enable_q;
						end
					end
					default: req.err = 1'b1;
				endcase
			end
			OP_LOAD: begin
				rom_full = load_full;
				if (load_full < ROM_TOTAL_W) begin
					req.rom_we = fire;
				end else begin
					req.err = 1'b1;
				end
			end
			default: req.err = 1'b1;
		endcase
	end

	assign rom_addr = rom_full[ROM_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bank_q   <= 5'd1;
			upper_bits_q <= 2'd0;
			ram_enable_q <= 1'b0;
			ram_mode_q   <= 1'b0;
		end else if (wr_regs) begin
			case (rgn)
				RGN_ENABLE: begin
					if (ram_used_q != 3'd0) begin
						ram_enable_q <= data[3:0] == RAM_EN_KEY;
					end
				end
				RGN_LOWBANK: low_bank_q   <= (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
				RGN_UPPER:   upper_bits_q <= data[1:0];
				RGN_MODE:    ram_mode_q   <= data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_used_q <= ROM_USED_RST;
			ram_used_q <= RAM_USED_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_ROM_USED: rom_used_q <= cfg_data;
				CFG_RAM_USED: ram_used_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	a_low_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		low_bank_q != 5'd0) else $error("low bank became zero");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({req.rom_re, req.rom_we, req.ram_re, req.ram_we}) <= 1)
		else $error("more than one memory access per beat");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.err |-> !(req.rom_we || req.ram_we || wr_regs))
		else $error("erroneous beat changes state");
	a_no_ram_off: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_used_q == 3'd0) |=> (ram_used_q != 3'd0) || $stable(ram_enable_q))
		else $error("ram enable changed with no ram present");

endmodule
`default_nettype wire

@@ hdl/cartridge_bank_mapper_unit.sv @@
// top level of the cartridge bank mapper: decode, memories and result stages
// One bus access is taken per beat and every beat gives one result. An input beat
// is decoded and its ROM or RAM access issued in the cycle it is accepted; the
// single-port memories return data in the next cycle into stage one, and the
// result then sits in an output register; a new beat can be accepted every cycle
// while the output side keeps up. Bank and mode writes take effect for the very
// next beat. The ROM and RAM contents are undefined until written; there is no
// clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module cartridge_bank_mapper_unit #(
	parameter int ROM_BANKS = 8,
	parameter int RAM_BANKS = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       op,
	input  wire logic [15:0]                      bus_address,
	input  wire logic [16:0]                      load_offset,
	input  wire logic [7:0]                       data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            read_data,
	output logic                                  access_error,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cbm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [7:0]                       cfg_data
);
	import cbm_pkg::*;

	localparam int ROM_DEPTH = ROM_BANKS*ROM_BANK_BYTES;
	localparam int RAM_DEPTH = RAM_BANKS*RAM_BANK_BYTES;

	logic                         in_fire;
	logic                         adv;
	cbm_req_t                     req;
	logic [$clog2(ROM_DEPTH)-1:0] rom_addr;
	logic [$clog2(RAM_DEPTH)-1:0] ram_addr;
	logic [7:0]                   rom_rdata;
	logic [7:0]                   ram_rdata;

	logic       v_s1;
	src_t       src_s1;
	logic       err_s1;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       access_error_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !v_s1 || adv;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	cbm_ctrl #(.ROM_BANKS(ROM_BANKS), .RAM_BANKS(RAM_BANKS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.op          (op),
		.bus_address (bus_address),
		.load_offset (load_offset),
		.data        (data),
		.cfg_fire    (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rom_addr    (rom_addr),
		.ram_addr    (ram_addr),
		.req         (req)
	);

	cbm_bytemem #(.DEPTH(ROM_DEPTH)) u_rom (
		.clk   (clk),
		.re    (req.rom_re),
		.we    (req.rom_we),
		.addr  (rom_addr),
		.wdata (data),
		.rdata (rom_rdata)
	);

	cbm_bytemem #(.DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.re    (req.ram_re),
		.we    (req.ram_we),
		.addr  (ram_addr),
		.wdata (data),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			src_s1 <= req.src;
			err_s1 <= req.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			access_error_q <= err_s1;
			case (src_s1)
				SRC_ROM: read_data_q <= rom_rdata;
				SRC_RAM: read_data_q <= ram_rdata;
				default: read_data_q <= BYTE_FF;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign access_error = access_error_q;

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> v_s1) else $error("accepted beat lost before stage one");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv && !in_fire) |=> v_s1 && $stable(src_s1) && $stable(err_s1))
		else $error("stalled stage one changed");
	a_err_ff: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && err_s1) |-> (src_s1 == SRC_FF))
		else $error("erroneous beat reads memory");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(read_data_q))
		else $error("stalled result changed");

endmodule
`default_nettype wire
